// ===== design/transaction_stream_parser_unit_assert.svh =====
// Assertion macros used by the parser RTL.
`ifndef TRANSACTION_STREAM_PARSER_UNIT_ASSERT_SVH
`define TRANSACTION_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tsp_pkg.sv =====
// Types and constants for the transaction stream parser.
package tsp_pkg;

    // Parse phases; a field result carries the phase it completed in as its kind.
    typedef enum logic [3:0] {
        PH_VERSION     = 4'd0,
        PH_IN_COUNT    = 4'd1,
        PH_PREV_ID     = 4'd2,
        PH_PREV_INDEX  = 4'd3,
        PH_IN_SLEN     = 4'd4,
        PH_IN_SCRIPT   = 4'd5,
        PH_SEQUENCE    = 4'd6,
        PH_OUT_COUNT   = 4'd7,
        PH_AMOUNT      = 4'd8,
        PH_OUT_SLEN    = 4'd9,
        PH_OUT_SCRIPT  = 4'd10,
        PH_LOCK_TIME   = 4'd11,
        PH_DONE        = 4'd12
    } phase_t;

    localparam logic [3:0] KIND_TRUNC = 4'd12;

    localparam int PREV_ID_BYTES = 32;

    // First compact-size byte at or above this is a length prefix.
    localparam logic [7:0] CS_PREFIX_MIN = 8'hfd;

    localparam logic [3:0] WORD_BYTES   = 4'd4;
    localparam logic [3:0] AMOUNT_BYTES = 4'd8;

    // Result queue: power-of-two depth, up to two results pushed per item.
    localparam int FIFO_DEPTH  = 4;
    localparam int MAX_RESULTS = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [31:0] entry;
        logic [31:0] offset;
        logic        complete;
        logic        last;
    } result_t;

endpackage

// ===== design/transaction_stream_parser_unit.sv =====
// Byte-serial legacy transaction parser with a small result queue.
// An item is registered in the input register when accepted, then parsed into the
// result queue once the queue has room; results are shown from the queue head.
// Throughput: one item per cycle while the result queue has room; the single result
// port takes one result per cycle unless out_stall is high, so two results need two pops.
// Reset: rst_n (async, active low) returns the parser to the version field and
// empties the input register and the result queue.
module transaction_stream_parser_unit
    import tsp_pkg::*;
#(
    parameter int PREV_ID_LEN = PREV_ID_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        frame_end,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_kind,
    output logic [63:0] field_value,
    output logic [31:0] entry_index,
    output logic [31:0] byte_offset,
    output logic        tx_complete,
    output logic        last_of_run
);

`include "transaction_stream_parser_unit_assert.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] PUSH_ROOM = CNT_W'(FIFO_DEPTH - MAX_RESULTS);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic       in_full_reg;
    logic [7:0] byte_reg;
    logic       fe_reg;
    logic       accept;
    logic       process;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    phase_t      phase_reg,      phase_next;
    logic [3:0]  cnt_reg,        cnt_next;
    logic [63:0] acc_reg,        acc_next;
    logic [1:0]  csw_reg,        csw_next;
    logic [63:0] in_left_reg,    in_left_next;
    logic [63:0] out_left_reg,   out_left_next;
    logic [63:0] script_left_reg, script_left_next;
    logic [31:0] entry_reg,      entry_next;
    logic [31:0] offset_reg,     offset_next;
    logic        done_reg,       done_next;

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    // Per-item work
    result_t     res0;
    result_t     res1;
    logic [1:0]  n_res;
    logic        have;
    logic [63:0] val;
    logic [63:0] byte_ext;
    logic [3:0]  need;
    logic [2:0]  lane;
    logic [31:0] entry_inc;
    logic [31:0] offset_inc;
    logic [63:0] in_dec;
    logic [63:0] out_dec;
    logic [63:0] script_dec;
    logic        prev_id_end;

    // Take a new item whenever the input register is free or drains this cycle.
    assign process  = in_full_reg && (count_reg <= PUSH_ROOM);
    assign in_stall = in_full_reg && !process;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (process)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // Item payload needs no reset; hold it until the parser takes it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
            fe_reg   <= frame_end;
        end
    end

    // Shared increments and decrements; at most one of each is used per item.
    assign byte_ext    = {56'd0, byte_reg};
    assign entry_inc   = (entry_reg == '1) ? entry_reg : entry_reg + 32'd1;
    assign offset_inc  = (offset_reg == '1) ? offset_reg : offset_reg + 32'd1;
    assign in_dec      = in_left_reg - 64'd1;
    assign out_dec     = out_left_reg - 64'd1;
    assign script_dec  = script_left_reg - 64'd1;
    assign prev_id_end = ({1'b0, offset_reg} + 33'd1) >= 33'(PREV_ID_LEN);
    assign need        = 4'd1 + (4'd1 << csw_reg);
    assign lane        = (cnt_reg == 4'd0) ? cnt_reg[2:0] : 3'(cnt_reg - 4'd1);

    always_comb
    begin
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        csw_next         = csw_reg;
        in_left_next     = in_left_reg;
        out_left_next    = out_left_reg;
        script_left_next = script_left_reg;
        entry_next       = entry_reg;
        offset_next      = offset_reg;
        done_next        = done_reg;
        have             = 1'b0;
        val              = '0;
        res0             = '0;
        res1             = '0;
        n_res            = 2'd0;

        case (phase_reg)
            PH_VERSION, PH_PREV_INDEX, PH_SEQUENCE, PH_AMOUNT, PH_LOCK_TIME:
            begin
                // Fixed-width little-endian field.
                acc_next = acc_reg | (byte_ext << {cnt_reg[2:0], 3'b000});
                cnt_next = cnt_reg + 4'd1;
                if (cnt_next >= ((phase_reg == PH_AMOUNT) ? AMOUNT_BYTES : WORD_BYTES))
                begin
                    have = 1'b1;
                    val  = acc_next;
                end
            end
            PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN:
            begin
                if (cnt_reg == 4'd0)
                begin
                    if (byte_reg < CS_PREFIX_MIN)
                    begin
                        have = 1'b1;
                        val  = byte_ext;
                    end
                    else
                    begin
                        // 0xfd, 0xfe, 0xff select 2, 4, 8 trailing bytes.
                        csw_next = byte_reg[1:0];
                        cnt_next = 4'd1;
                        acc_next = '0;
                    end
                end
                else
                begin
                    acc_next = acc_reg | (byte_ext << {lane, 3'b000});
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= need)
                    begin
                        have = 1'b1;
                        val  = acc_next;
                    end
                end
            end
            PH_PREV_ID:
            begin
                res0  = '{kind: PH_PREV_ID, value: byte_ext, entry: entry_reg,
                          offset: offset_reg, complete: 1'b0, last: 1'b0};
                n_res = 2'd1;
                if (prev_id_end)
                begin
                    phase_next  = PH_PREV_INDEX;
                    offset_next = '0;
                end
                else
                begin
                    offset_next = offset_reg + 32'd1;
                end
            end
            PH_IN_SCRIPT, PH_OUT_SCRIPT:
            begin
                res0  = '{kind: phase_reg, value: byte_ext, entry: entry_reg,
                          offset: offset_reg, complete: 1'b0, last: 1'b0};
                n_res            = 2'd1;
                offset_next      = offset_inc;
                script_left_next = script_dec;
                if (script_dec == 64'd0)
                begin
                    offset_next = '0;
                    if (phase_reg == PH_IN_SCRIPT)
                    begin
                        phase_next = PH_SEQUENCE;
                    end
                    else
                    begin
                        // Close this output, advance to the next or to lock time.
                        out_left_next = out_dec;
                        entry_next    = (out_dec == 64'd0) ? 32'd0 : entry_inc;
                        phase_next    = (out_dec == 64'd0) ? PH_LOCK_TIME : PH_AMOUNT;
                    end
                end
            end
            default:
            begin
                // Trailing bytes after lock time: drop.
            end
        endcase

        if (have)
        begin
            res0  = '{kind: phase_reg, value: val, entry: entry_reg, offset: 32'd0,
                      complete: (phase_reg == PH_LOCK_TIME), last: 1'b0};
            n_res    = 2'd1;
            cnt_next = '0;
            acc_next = '0;
            csw_next = '0;
            case (phase_reg)
                PH_VERSION:
                begin
                    phase_next = PH_IN_COUNT;
                end
                PH_IN_COUNT:
                begin
                    in_left_next = val;
                    entry_next   = '0;
                    if (val == 64'd0)
                    begin
                        phase_next = PH_OUT_COUNT;
                    end
                    else
                    begin
                        phase_next  = PH_PREV_ID;
                        offset_next = '0;
                    end
                end
                PH_PREV_INDEX:
                begin
                    phase_next = PH_IN_SLEN;
                end
                PH_IN_SLEN:
                begin
                    script_left_next = val;
                    offset_next      = '0;
                    phase_next       = (val == 64'd0) ? PH_SEQUENCE : PH_IN_SCRIPT;
                end
                PH_SEQUENCE:
                begin
                    in_left_next = in_dec;
                    if (in_dec == 64'd0)
                    begin
                        entry_next = '0;
                        phase_next = PH_OUT_COUNT;
                    end
                    else
                    begin
                        entry_next  = entry_inc;
                        phase_next  = PH_PREV_ID;
                        offset_next = '0;
                    end
                end
                PH_OUT_COUNT:
                begin
                    out_left_next = val;
                    entry_next    = '0;
                    phase_next    = (val == 64'd0) ? PH_LOCK_TIME : PH_AMOUNT;
                end
                PH_AMOUNT:
                begin
                    phase_next = PH_OUT_SLEN;
                end
                PH_OUT_SLEN:
                begin
                    script_left_next = val;
                    offset_next      = '0;
                    if (val == 64'd0)
                    begin
                        out_left_next = out_dec;
                        entry_next    = (out_dec == 64'd0) ? 32'd0 : entry_inc;
                        phase_next    = (out_dec == 64'd0) ? PH_LOCK_TIME : PH_AMOUNT;
                    end
                    else
                    begin
                        phase_next = PH_OUT_SCRIPT;
                    end
                end
                PH_LOCK_TIME:
                begin
                    done_next  = 1'b1;
                    phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        if (fe_reg)
        begin
            // Frame end: report truncation unless lock time finished, then restart.
            if (!done_next)
            begin
                if (n_res == 2'd0)
                begin
                    res0 = '{kind: KIND_TRUNC, value: 64'd0, entry: entry_next,
                             offset: 32'd0, complete: 1'b0, last: 1'b0};
                end
                else
                begin
                    res1 = '{kind: KIND_TRUNC, value: 64'd0, entry: entry_next,
                             offset: 32'd0, complete: 1'b0, last: 1'b0};
                end
                n_res = n_res + 2'd1;
            end
            phase_next       = PH_VERSION;
            cnt_next         = '0;
            acc_next         = '0;
            csw_next         = '0;
            in_left_next     = '0;
            out_left_next    = '0;
            script_left_next = '0;
            entry_next       = '0;
            offset_next      = '0;
            done_next        = 1'b0;
        end

        // Mark the final result of this item.
        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_VERSION;
            cnt_reg         <= '0;
            acc_reg         <= '0;
            csw_reg         <= '0;
            in_left_reg     <= '0;
            out_left_reg    <= '0;
            script_left_reg <= '0;
            entry_reg       <= '0;
            offset_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else if (process)
        begin
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            acc_reg         <= acc_next;
            csw_reg         <= csw_next;
            in_left_reg     <= in_left_next;
            out_left_reg    <= out_left_next;
            script_left_reg <= script_left_next;
            entry_reg       <= entry_next;
            offset_reg      <= offset_next;
            done_reg        <= done_next;
        end
    end

    // ---------------------------------------------------------------
    // Result queue: push up to two results per item; unless stalled, pop one per cycle
    // ---------------------------------------------------------------
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (process && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (process && (n_res == 2'd2))
        begin
            fifo_reg[wr_ptr_inc] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (process)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (process ? CNT_W'(n_res) : CNT_W'(0))
                         - CNT_W'(pop);
        end
    end

    assign field_kind  = fifo_reg[rd_ptr_reg].kind;
    assign field_value = fifo_reg[rd_ptr_reg].value;
    assign entry_index = fifo_reg[rd_ptr_reg].entry;
    assign byte_offset = fifo_reg[rd_ptr_reg].offset;
    assign tx_complete = fifo_reg[rd_ptr_reg].complete;
    assign last_of_run = fifo_reg[rd_ptr_reg].last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TSP_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH),
                    "result queue overflow")
    `TSP_ASSERT_NEXT(a_frame_restart, process && fe_reg,
                     phase_reg == PH_VERSION && !done_reg,
                     "frame end did not restart parser")
    `TSP_ASSERT_NOW(a_done_phase, done_reg, phase_reg == PH_DONE,
                    "done flag outside done phase")
    `TSP_ASSERT_NOW(a_stall_only_full, in_stall, in_full_reg && count_reg > PUSH_ROOM,
                    "input stalled without cause")

endmodule

// ===== sim/transaction_stream_parser_unit_tb.sv =====
// Self-checking testbench for the byte-serial transaction stream parser.
`timescale 1ns / 1ps

module transaction_stream_parser_unit_tb;
    import tsp_pkg::*;

    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 900;
    // Start the long receiver hold-off once this many items have gone in.
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;
    // Extra wait after the last owed result, for the pipeline and the result queue.
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        frame_end;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic [31:0] entry_index;
    logic [31:0] byte_offset;
    logic        tx_complete;
    logic        last_of_run;

    transaction_stream_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_kind  (field_kind),
        .field_value (field_value),
        .entry_index (entry_index),
        .byte_offset (byte_offset),
        .tx_complete (tx_complete),
        .last_of_run (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Parser model: its own copy of the parse state.
    // ------------------------------------------------------------------
    phase_t      p_phase;
    logic [3:0]  p_cnt;
    logic [63:0] p_acc;
    logic [1:0]  p_cs;
    logic [63:0] p_ins;
    logic [63:0] p_outs;
    logic [63:0] p_script;
    logic [31:0] p_entry;
    logic [31:0] p_off;
    bit          p_done;

    // Results caused by the byte just decoded; a byte causes at most two.
    result_t     step_out [0:MAX_RESULTS-1];
    int          step_n;

    // Field results still owed by the block, oldest first.
    result_t     pending_fields [$];

    int          items_accepted = 0;
    int          results_seen = 0;
    int          errors = 0;
    bit          hold_off = 1'b0;

    function automatic logic [31:0] sat_up(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    function automatic void clear_model();
        p_phase  = PH_VERSION;
        p_cnt    = '0;
        p_acc    = '0;
        p_cs     = '0;
        p_ins    = '0;
        p_outs   = '0;
        p_script = '0;
        p_entry  = '0;
        p_off    = '0;
        p_done   = 1'b0;
    endfunction

    function automatic void emit(input logic [3:0] k, input logic [63:0] v,
                                 input logic [31:0] e, input logic [31:0] o, input bit c);
        step_out[step_n].kind     = k;
        step_out[step_n].value    = v;
        step_out[step_n].entry    = e;
        step_out[step_n].offset   = o;
        step_out[step_n].complete = c;
        step_out[step_n].last     = 1'b0;
        step_n++;
    endfunction

    // Finish one output entry: step to the next amount or on to the lock time.
    function automatic void close_output();
        p_outs  = p_outs - 64'd1;
        p_entry = sat_up(p_entry);
        if (p_outs == 0)
        begin
            p_entry = '0;
            p_phase = PH_LOCK_TIME;
        end
        else
            p_phase = PH_AMOUNT;
    endfunction

    // Move on once a whole field has been assembled.
    function automatic void next_field(input logic [63:0] v);
        case (p_phase)
            PH_VERSION:    p_phase = PH_IN_COUNT;
            PH_IN_COUNT:
            begin
                p_ins   = v;
                p_entry = '0;
                if (v == 0)
                    p_phase = PH_OUT_COUNT;
                else
                begin
                    p_phase = PH_PREV_ID;
                    p_off   = '0;
                end
            end
            PH_PREV_INDEX: p_phase = PH_IN_SLEN;
            PH_IN_SLEN:
            begin
                p_script = v;
                p_off    = '0;
                p_phase  = (v == 0) ? PH_SEQUENCE : PH_IN_SCRIPT;
            end
            PH_SEQUENCE:
            begin
                p_ins   = p_ins - 64'd1;
                p_entry = sat_up(p_entry);
                if (p_ins == 0)
                begin
                    p_entry = '0;
                    p_phase = PH_OUT_COUNT;
                end
                else
                begin
                    p_phase = PH_PREV_ID;
                    p_off   = '0;
                end
            end
            PH_OUT_COUNT:
            begin
                p_outs  = v;
                p_entry = '0;
                p_phase = (v == 0) ? PH_LOCK_TIME : PH_AMOUNT;
            end
            PH_AMOUNT:     p_phase = PH_OUT_SLEN;
            PH_OUT_SLEN:
            begin
                p_script = v;
                p_off    = '0;
                if (v == 0)
                    close_output();
                else
                    p_phase = PH_OUT_SCRIPT;
            end
            PH_LOCK_TIME:
            begin
                p_done  = 1'b1;
                p_phase = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // Decode one accepted byte into step_out / step_n.
    function automatic void decode_byte(input logic [7:0] b, input bit fe);
        phase_t      ph;
        bit          have;
        logic [63:0] val;
        int          width;
        int          need;
        logic [3:0]  pos;
        ph     = p_phase;
        have   = 1'b0;
        val    = '0;
        step_n = 0;
        case (ph)
            PH_VERSION, PH_PREV_INDEX, PH_SEQUENCE, PH_AMOUNT, PH_LOCK_TIME:
            begin
                width = (ph == PH_AMOUNT) ? 8 : 4;
                p_acc = p_acc | ({56'd0, b} << (8 * p_cnt[2:0]));
                p_cnt = p_cnt + 4'd1;
                if (p_cnt >= width)
                begin
                    val  = p_acc;
                    have = 1'b1;
                end
            end
            PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN:
            begin
                if (p_cnt == 0)
                begin
                    if (b < CS_PREFIX_MIN)
                    begin
                        val  = {56'd0, b};
                        have = 1'b1;
                    end
                    else
                    begin
                        // 0xfd, 0xfe, 0xff select 2, 4, 8 following bytes.
                        p_cs  = b[1:0];
                        p_cnt = 4'd1;
                        p_acc = '0;
                    end
                end
                else
                begin
                    need  = 1 + (1 << p_cs);
                    pos   = p_cnt - 4'd1;
                    p_acc = p_acc | ({56'd0, b} << (8 * pos[2:0]));
                    p_cnt = p_cnt + 4'd1;
                    if (p_cnt >= need)
                    begin
                        val  = p_acc;
                        have = 1'b1;
                    end
                end
            end
            PH_PREV_ID:
            begin
                emit(PH_PREV_ID, {56'd0, b}, p_entry, p_off, 1'b0);
                if (p_off + 32'd1 >= PREV_ID_BYTES)
                begin
                    p_phase = PH_PREV_INDEX;
                    p_off   = '0;
                end
                else
                    p_off = p_off + 32'd1;
            end
            PH_IN_SCRIPT, PH_OUT_SCRIPT:
            begin
                emit(ph, {56'd0, b}, p_entry, p_off, 1'b0);
                p_off    = sat_up(p_off);
                p_script = p_script - 64'd1;
                if (p_script == 0)
                begin
                    p_off = '0;
                    if (ph == PH_IN_SCRIPT)
                        p_phase = PH_SEQUENCE;
                    else
                        close_output();
                end
            end
            default: ;
        endcase

        if (have)
        begin
            emit(ph, val, p_entry, 32'd0, ph == PH_LOCK_TIME);
            p_cnt = '0;
            p_acc = '0;
            p_cs  = '0;
            next_field(val);
        end

        // A frame end before the lock time completes reports truncation.
        if (fe)
        begin
            if (!p_done)
                emit(KIND_TRUNC, 64'd0, p_entry, 32'd0, 1'b0);
            clear_model();
        end

        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one item, hold it until accepted, then predict.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit fe, input bit typed,
                             input result_t want);
        int gap;
        // Every third stretch of 64 items runs back to back.
        if (((items_accepted >> 6) % 3) == 1)
            gap = 0;
        else
            gap = $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        byte_in   <= b;
        frame_end <= fe;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_accepted++;
        decode_byte(b, fe);
        // A typed row stands in for the model's answer on that byte.
        if (typed)
            pending_fields.insert(pending_fields.size(), want);
        else
            for (int i = 0; i < step_n; i++)
                pending_fields.insert(pending_fields.size(), step_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] data;
        bit         last;
        bit         typed;
        result_t    want;
    } stim_row_t;

    stim_row_t stim_rows [$];

    function automatic void add_row(input logic [7:0] d, input bit l);
        stim_row_t row;
        row.data  = d;
        row.last  = l;
        row.typed = 1'b0;
        row.want  = '0;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Row whose single result is plain to see: entry and offset zero.
    function automatic void add_typed(input logic [7:0] d, input bit l, input logic [3:0] k,
                                      input logic [63:0] v, input bit c);
        stim_row_t row;
        row.data          = d;
        row.last          = l;
        row.typed         = 1'b1;
        row.want          = '0;
        row.want.kind     = k;
        row.want.value    = v;
        row.want.complete = c;
        row.want.last     = 1'b1;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Random frames.
    // ------------------------------------------------------------------
    logic [7:0] frame_bytes [$];

    function automatic void add_frame_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    function automatic void push_le(input logic [63:0] v, input int nb);
        for (int i = 0; i < nb; i++)
            add_frame_byte(v[8*i +: 8]);
    endfunction

    // Compact-size encoding, often deliberately non-minimal.
    function automatic void push_compact(input logic [63:0] v);
        int fmt;
        fmt = $urandom_range(0, 7);
        if (fmt < 5 && v < CS_PREFIX_MIN)
            add_frame_byte(v[7:0]);
        else if (fmt == 6)
        begin
            add_frame_byte(8'hfe);
            push_le(v, 4);
        end
        else if (fmt == 7)
        begin
            add_frame_byte(8'hff);
            push_le(v, 8);
        end
        else
        begin
            add_frame_byte(8'hfd);
            push_le(v, 2);
        end
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 9)
            return 0;
        if (r >= 7)
            return $urandom_range(5, 20);
        return $urandom_range(0, 4);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++)
            add_frame_byte(8'($urandom_range(0, 255)));
    endfunction

    // Fill frame_bytes: mostly well-formed transactions with random content,
    // some cut short, some with a huge input count, some pure noise.
    function automatic void build_frame();
        int mode;
        int n_in;
        int n_out;
        int slen;
        int keep;
        frame_bytes.delete();
        mode = $urandom_range(0, 9);
        if (mode == 0)
            push_random($urandom_range(1, 24));
        else if (mode == 1)
        begin
            push_le(64'(pick_word()), 4);
            add_frame_byte(8'hff);
            push_le({$urandom, $urandom}, 8);
            push_random($urandom_range(0, 40));
        end
        else
        begin
            push_le(64'(pick_word()), 4);
            n_in = $urandom_range(0, 3);
            push_compact(64'(n_in));
            for (int i = 0; i < n_in; i++)
            begin
                push_random(PREV_ID_BYTES);
                push_le(64'(pick_word()), 4);
                slen = pick_len();
                push_compact(64'(slen));
                push_random(slen);
                push_le(64'(pick_word()), 4);
            end
            n_out = $urandom_range(0, 3);
            push_compact(64'(n_out));
            for (int i = 0; i < n_out; i++)
            begin
                push_le({pick_word(), pick_word()}, 8);
                slen = pick_len();
                push_compact(64'(slen));
                push_random(slen);
            end
            push_le(64'(pick_word()), 4);
            if ($urandom_range(0, 3) == 0)
                push_random($urandom_range(1, 5));
            // Cut the frame short somewhere.
            if (mode >= 8 && frame_bytes.size() > 1)
            begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int random_start;
        rst_n = 1'b0;
        in_valid  <= 1'b0;
        byte_in   <= 8'd0;
        frame_end <= 1'b0;
        clear_model();

        // Frame end on the very first byte: truncated at once.
        add_typed(8'h00, 1'b1, KIND_TRUNC, 64'd0, 1'b0);
        // Largest version.
        add_row(8'hff, 1'b0);
        add_row(8'hff, 1'b0);
        add_row(8'hff, 1'b0);
        add_typed(8'hff, 1'b0, PH_VERSION, 64'hffff_ffff, 1'b0);
        // Zero input count sent non-minimally: the 0xfd prefix and two trailing bytes.
        add_row(8'hfd, 1'b0);
        add_row(8'h00, 1'b0);
        add_typed(8'h00, 1'b0, PH_IN_COUNT, 64'd0, 1'b0);
        // Zero outputs: straight to the lock time.
        add_typed(8'h00, 1'b0, PH_OUT_COUNT, 64'd0, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_typed(8'h00, 1'b0, PH_LOCK_TIME, 64'd0, 1'b1);
        // Trailing bytes and the frame end after completion: no result.
        add_row(8'hff, 1'b0);
        add_row(8'ha5, 1'b1);
        // Next frame: version 1, then the largest 8-byte input count.
        add_row(8'h01, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_typed(8'h00, 1'b0, PH_VERSION, 64'd1, 1'b0);
        add_row(8'hff, 1'b0);
        for (int i = 0; i < 7; i++)
            add_row(8'hff, 1'b0);
        add_typed(8'hff, 1'b0, PH_IN_COUNT, 64'hffff_ffff_ffff_ffff, 1'b0);
        // One previous-id byte, then the frame ends: byte plus truncation.
        add_row(8'h5a, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].typed,
                      stim_rows[i].want);

        random_start = items_accepted;
        while (items_accepted - random_start < RANDOM_ITEMS)
        begin
            build_frame();
            for (int i = 0; i < frame_bytes.size(); i++)
                send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall at random, take each result and check it.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int      gap;
        result_t got;
        result_t want;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (((results_seen >> 6) % 3) == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 9);
            if (gap > 0 || hold_off)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                // Hold off as long as the pressure window stays open.
                while (hold_off)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            results_seen++;
            got.kind     = field_kind;
            got.value    = field_value;
            got.entry    = entry_index;
            got.offset   = byte_offset;
            got.complete = tx_complete;
            got.last     = last_of_run;
            if (pending_fields.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d value %h", $time,
                         got.kind, got.value);
                errors++;
            end
            else
            begin
                want = pending_fields.pop_front();
                if (got.kind !== want.kind)
                begin
                    $display("%0t: field_kind expected %0d actual %0d", $time,
                             want.kind, got.kind);
                    errors++;
                end
                if (got.value !== want.value)
                begin
                    $display("%0t: field_value expected %h actual %h", $time,
                             want.value, got.value);
                    errors++;
                end
                if (got.entry !== want.entry)
                begin
                    $display("%0t: entry_index expected %h actual %h", $time,
                             want.entry, got.entry);
                    errors++;
                end
                if (got.offset !== want.offset)
                begin
                    $display("%0t: byte_offset expected %h actual %h", $time,
                             want.offset, got.offset);
                    errors++;
                end
                if (got.complete !== want.complete)
                begin
                    $display("%0t: tx_complete expected %b actual %b", $time,
                             want.complete, got.complete);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Pressure window: the sink stops taking results for a long stretch
    // while items keep coming, so the result queue fills and in_stall rises.
    initial
    begin : pressure_window
        wait (items_accepted >= HOLD_START);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end a hung run.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
